// ----- rtl/core/neighbor_table_aging_top_macros.svh -----
// Assertion shorthands for the neighbour table checker.
// Every property is clocked on clk and switched off while rst_n is low.
`ifndef NEIGHBOR_TABLE_AGING_TOP_MACROS_SVH
`define NEIGHBOR_TABLE_AGING_TOP_MACROS_SVH

// Same-cycle implication
`define NTA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define NTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/nta_pkg.sv -----
`timescale 1ns / 1ps

package nta_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int IP_W      = 32;
  localparam int PORT_W    = 16;
  localparam int KEY_W     = IP_W + PORT_W;
  localparam int STAMP_W   = 32;
  localparam int ENTRY_W   = KEY_W + STAMP_W;
  localparam int ELAPSED_W = 16;
  localparam int LIVE_W    = 5;
  localparam int LIVE_MAX  = 31;

  localparam logic [STAMP_W-1:0] TIMEOUT_RESET = 32'd5000;

  // Command codes
  localparam logic CMD_PING = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic load;     // capture an accepted transaction
    logic scan_en;  // issue one table read and advance the index
    logic commit;   // apply the outcome and load the result register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_last;  // the read being issued is for the last entry
    logic out_free;   // result register can take a new result
  } dp_status_t;

endpackage

// ----- rtl/core/nta_in_if.sv -----
`timescale 1ns / 1ps

interface nta_in_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [nta_pkg::IP_W-1:0]       ip_address;
  logic [nta_pkg::PORT_W-1:0]     port_number;
  logic [nta_pkg::ELAPSED_W-1:0]  elapsed;

  modport source (output valid, cmd, ip_address, port_number, elapsed, input ready);
  modport sink   (input valid, cmd, ip_address, port_number, elapsed, output ready);
endinterface

// ----- rtl/core/nta_out_if.sv -----
`timescale 1ns / 1ps

interface nta_out_if;
  logic                        valid;
  logic                        ready;
  logic                        changed;
  logic                        table_full;
  logic [nta_pkg::LIVE_W-1:0]  live_count;

  modport source (output valid, changed, table_full, live_count, input ready);
  modport sink   (input valid, changed, table_full, live_count, output ready);
endinterface

// ----- rtl/core/neighbor_table_aging_top.sv -----
`timescale 1ns / 1ps

// Neighbour table with aging timeout. Keeps up to TABLE_DEPTH live neighbours,
// keyed by {IPv4 address, port}, each with a 32-bit last-seen stamp. A ping
// transaction (cmd 0) refreshes a known key or inserts an unknown one into
// the lowest free entry; when no entry is free it is dropped and table_full
// is set. A tick transaction (cmd 1) adds elapsed to the wrapping time
// counter and evicts every entry whose age exceeds the timeout (cfg port).
// Every transaction gives exactly one result with changed, table_full and the
// live count after it (saturating at 31). One transaction is handled at a
// time: the entry memory is swept one entry per cycle through its single
// registered read port, then a drain state compares the last read and a
// commit state applies the outcome. A result may sit in the output register
// while the next transaction is accepted; the commit waits only if that
// register is still full. Keys and stamps live in a RAM with no reset;
// valid bits sit in flops cleared by reset, so no clearing pass is needed.
// Write the timeout only while no transaction is in flight; the register
// itself takes a write on any cycle.

module neighbor_table_aging_top #(
  parameter int TABLE_DEPTH = nta_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  nta_in_if.sink                       in_ch,
  nta_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [nta_pkg::STAMP_W-1:0]  cfg_wdata
);

  nta_pkg::ctrl_cmd_t  cmd;
  nta_pkg::dp_status_t status;
  logic                in_ready;

  // Sequencer: idle / sweep / drain / commit
  nta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // Entry store, time counter, timeout register and result register
  nta_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_cmd         (in_ch.cmd),
    .in_ip_address  (in_ch.ip_address),
    .in_port_number (in_ch.port_number),
    .in_elapsed     (in_ch.elapsed),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_changed    (out_ch.changed),
    .out_table_full (out_ch.table_full),
    .out_live_count (out_ch.live_count)
  );

endmodule

// ----- rtl/core/nta_ram.sv -----
`timescale 1ns / 1ps

module nta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/nta_ctrl.sv -----
`timescale 1ns / 1ps

module nta_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  nta_pkg::dp_status_t    status,
  output nta_pkg::ctrl_cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read comes back and is compared here
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/nta_dp.sv -----
`timescale 1ns / 1ps

module nta_dp #(
  parameter int TABLE_DEPTH = nta_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  nta_pkg::ctrl_cmd_t                cmd,
  output nta_pkg::dp_status_t               status,
  input  logic                              in_cmd,
  input  logic [nta_pkg::IP_W-1:0]          in_ip_address,
  input  logic [nta_pkg::PORT_W-1:0]        in_port_number,
  input  logic [nta_pkg::ELAPSED_W-1:0]     in_elapsed,
  input  logic                              cfg_we,
  input  logic [nta_pkg::STAMP_W-1:0]       cfg_wdata,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_changed,
  output logic                              out_table_full,
  output logic [nta_pkg::LIVE_W-1:0]        out_live_count
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SAT_W = (CNT_W > nta_pkg::LIVE_W) ? CNT_W : nta_pkg::LIVE_W;

  logic                           cmd_r;
  logic [nta_pkg::KEY_W-1:0]      key_r;
  logic [nta_pkg::STAMP_W-1:0]    time_r;
  logic [nta_pkg::STAMP_W-1:0]    timeout_r;
  logic [TABLE_DEPTH-1:0]         valid_r;
  logic [CNT_W-1:0]               cnt_r;

  logic [IDX_W-1:0]               scan_idx_r;
  logic                           cmp_vld_r;
  logic [IDX_W-1:0]               cmp_idx_r;

  logic                           hit_r;
  logic [IDX_W-1:0]               hit_idx_r;
  logic                           free_r;
  logic [IDX_W-1:0]               free_idx_r;
  logic                           evict_r;

  logic                           out_valid_r;
  logic                           out_changed_r;
  logic                           out_full_r;
  logic [nta_pkg::LIVE_W-1:0]     out_live_r;

  logic [nta_pkg::ENTRY_W-1:0]    rd_data;
  logic [nta_pkg::KEY_W-1:0]      rd_key;
  logic [nta_pkg::STAMP_W-1:0]    rd_stamp;
  logic [nta_pkg::STAMP_W-1:0]    age;
  logic                           cmp_valid;
  logic                           is_ping;
  logic                           ins;
  logic                           ram_we;
  logic [IDX_W-1:0]               ram_waddr;
  logic [CNT_W-1:0]               cnt_after;
  logic [SAT_W-1:0]               cnt_wide;
  logic [nta_pkg::LIVE_W-1:0]     live_sat;

  nta_ram #(
    .WIDTH (nta_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({key_r, time_r}),
    .re    (cmd.scan_en),
    .raddr (scan_idx_r),
    .rdata (rd_data)
  );

  assign rd_key    = rd_data[nta_pkg::ENTRY_W-1:nta_pkg::STAMP_W];
  assign rd_stamp  = rd_data[nta_pkg::STAMP_W-1:0];
  assign age       = time_r - rd_stamp;
  assign cmp_valid = valid_r[cmp_idx_r];
  assign is_ping   = (cmd_r == nta_pkg::CMD_PING);
  assign ins       = is_ping && !hit_r && free_r;
  assign ram_we    = cmd.commit && is_ping && (hit_r || free_r);
  assign ram_waddr = hit_r ? hit_idx_r : free_idx_r;

  always_comb begin
    cnt_after = cnt_r + CNT_W'(ins);
    cnt_wide  = SAT_W'(cnt_after);
    if (cnt_wide > SAT_W'(nta_pkg::LIVE_MAX)) begin
      live_sat = nta_pkg::LIVE_W'(nta_pkg::LIVE_MAX);
    end else begin
      live_sat = cnt_wide[nta_pkg::LIVE_W-1:0];
    end
  end

  assign status.scan_last = (scan_idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign status.out_free  = !out_valid_r || out_ready;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r      <= '0;
      timeout_r   <= nta_pkg::TIMEOUT_RESET;
      valid_r     <= '0;
      cnt_r       <= '0;
      scan_idx_r  <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      evict_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      cmp_vld_r <= cmd.scan_en;
      if (cmd.load) begin
        scan_idx_r <= '0;
        hit_r      <= 1'b0;
        free_r     <= 1'b0;
        evict_r    <= 1'b0;
        if (in_cmd == nta_pkg::CMD_TICK) begin
          time_r <= time_r + nta_pkg::STAMP_W'(in_elapsed);
        end
      end else if (cmd.scan_en) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cmp_vld_r) begin
        if (is_ping) begin
          if (cmp_valid && !hit_r && (rd_key == key_r)) begin
            hit_r <= 1'b1;
          end
          if (!cmp_valid && !free_r) begin
            free_r <= 1'b1;
          end
        end else if (cmp_valid && (age > timeout_r)) begin
          valid_r[cmp_idx_r] <= 1'b0;
          cnt_r              <= cnt_r - 1'b1;
          evict_r            <= 1'b1;
        end
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (ins) begin
          valid_r[free_idx_r] <= 1'b1;
          cnt_r               <= cnt_after;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_idx_r;
    if (cmd.load) begin
      cmd_r <= in_cmd;
      key_r <= {in_ip_address, in_port_number};
    end
    if (cmp_vld_r && is_ping) begin
      if (cmp_valid && !hit_r && (rd_key == key_r)) begin
        hit_idx_r <= cmp_idx_r;
      end
      if (!cmp_valid && !free_r) begin
        free_idx_r <= cmp_idx_r;
      end
    end
    if (cmd.commit) begin
      out_changed_r <= is_ping ? ins : evict_r;
      out_full_r    <= is_ping && !hit_r && !free_r;
      out_live_r    <= live_sat;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_changed    = out_changed_r;
  assign out_table_full = out_full_r;
  assign out_live_count = out_live_r;

endmodule

// ----- rtl/core/nta_checker.sv -----
`timescale 1ns / 1ps
`include "neighbor_table_aging_top_macros.svh"

module nta_checker #(
  parameter int TABLE_DEPTH = nta_pkg::TABLE_DEPTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_changed,
  input logic                         out_table_full,
  input logic [nta_pkg::LIVE_W-1:0]   out_live_count
);

  localparam int LIVE_CAP = (TABLE_DEPTH > nta_pkg::LIVE_MAX) ? nta_pkg::LIVE_MAX
                                                               : TABLE_DEPTH;

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid && in_ready;
  assign out_stall = out_valid && !out_ready;

  // a stalled result holds
  `NTA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable({out_changed, out_table_full, out_live_count}), "stalled result changed")

  // one transaction at a time: sweep starts straight after acceptance
  `NTA_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready, "accepted while sweeping")

  // a dropped neighbour means the table is full and nothing changed
  `NTA_ASSERT_NOW(a_full_result, out_valid && out_table_full, !out_changed && (out_live_count == nta_pkg::LIVE_W'(LIVE_CAP)), "table_full with spare room or change")

  // live count never exceeds the table
  `NTA_ASSERT_NOW(a_count_cap, out_valid, out_live_count <= nta_pkg::LIVE_W'(LIVE_CAP), "live count above capacity")

endmodule

bind neighbor_table_aging_top nta_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_nta_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_changed    (out_ch.changed),
  .out_table_full (out_ch.table_full),
  .out_live_count (out_ch.live_count)
);
